/* rtl/assert_macros.svh */
// Assertion macros used by the checker of the steering block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CFW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CFW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cfw_pkg.sv */
// Shared types, constants and the CORDIC angle table for the steering block.
// No dependencies; the interface, CORDIC, top-level and bench files import this package.
package cfw_pkg;

  // CORDIC datapath
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int CW            = 28;   // vector width, covers gain and sign
  localparam int ZW            = 24;   // angle width, units of 2^-24 turn
  localparam logic [ZW-1:0] Z_HALF  = 24'h800000;
  localparam logic [ZW-1:0] Z_ROUND = 24'd128;

  // Steering and PWM datapath
  localparam int ERR_W  = 16;
  localparam int DW     = 26;          // wheel speed difference, Q8
  localparam int VW     = 27;          // wheel speed, Q8
  localparam int AW     = 45;          // PWM accumulator, Q16
  localparam int NPOST  = 8;           // register stages after the CORDIC
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [63:0] RND_HALF36 = 64'h0000_0008_0000_0000;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGULAR_GAIN  = 3'd0,
    CFG_HALF_AXLE     = 3'd1,
    CFG_FORWARD_SPEED = 3'd2,
    CFG_PWM_SLOPE     = 3'd3,
    CFG_PWM_OFFSET    = 3'd4
  } cfw_cfg_idx_e;

  localparam logic [15:0]        RST_GAIN   = 16'd6144;
  localparam logic [9:0]         RST_HALF   = 10'd85;
  localparam logic signed [11:0] RST_FWD    = 12'sd25;
  localparam logic [15:0]        RST_SLOPE  = 16'd14147;
  localparam logic signed [23:0] RST_OFFSET = 24'sd240216;

  // One word inside the CORDIC pipeline.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ZW-1:0]        z;
    logic                 is_zero;
    logic [15:0]          heading;
  } cfw_cordic_t;

  // atan(2^-i) in units of 2^-24 turn.
  function automatic logic [ZW-1:0] cfw_atan(input int unsigned i);
    case (i)
      0:  return 24'd2097152;
      1:  return 24'd1238021;
      2:  return 24'd654136;
      3:  return 24'd332050;
      4:  return 24'd166669;
      5:  return 24'd83416;
      6:  return 24'd41718;
      7:  return 24'd20860;
      8:  return 24'd10430;
      9:  return 24'd5215;
      10: return 24'd2608;
      11: return 24'd1304;
      12: return 24'd652;
      13: return 24'd326;
      14: return 24'd163;
      15: return 24'd81;
      16: return 24'd41;
      17: return 24'd20;
      18: return 24'd10;
      19: return 24'd5;
      20: return 24'd3;
      21: return 24'd1;
      22: return 24'd1;
      23: return 24'd0;
      default: return '0;
    endcase
  endfunction

endpackage

/* rtl/cfw_if.sv */
// Handshake interfaces of the steering block: pose input, PWM output, config writes.
// Depends on cfw_pkg for the configuration field widths.
interface cfw_pose_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] pose_x;
  logic signed [15:0] pose_y;
  logic signed [15:0] pose_heading;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;

  modport source (output valid, pose_x, pose_y, pose_heading, target_x, target_y,
                  input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, target_x, target_y,
                  output ready);
endinterface

interface cfw_pwm_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] pwm_left;
  logic signed [15:0] pwm_right;
  logic signed [15:0] heading_error;
  logic               saturated;

  modport source (output valid, pwm_left, pwm_right, heading_error, saturated,
                  input ready);
  modport sink   (input valid, pwm_left, pwm_right, heading_error, saturated,
                  output ready);
endinterface

interface cfw_cfg_if import cfw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/cfw_cordic.sv */
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
// Depends on cfw_pkg for the word type, stage count and angle table.
module cfw_cordic import cfw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cfw_cordic_t in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cfw_cordic_t out_data_o
);

  cfw_cordic_t               stg_q [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0]  vld_q;
  logic [CORDIC_STAGES:0]    adv;

  assign adv[CORDIC_STAGES] = out_ready_i;
  assign in_ready_o         = adv[0];
  assign out_valid_o        = vld_q[CORDIC_STAGES-1];
  assign out_data_o         = stg_q[CORDIC_STAGES-1];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    cfw_cordic_t          cur;
    cfw_cordic_t          nxt;
    logic                 cur_vld;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    if (i == 0) begin : g_first
      assign cur     = in_data_i;
      assign cur_vld = in_valid_i;
    end else begin : g_next
      assign cur     = stg_q[i-1];
      assign cur_vld = vld_q[i-1];
    end

    // A stage takes a new word when it is empty or its successor moves.
    assign adv[i] = ~vld_q[i] | adv[i+1];

    // Rotate toward the x axis; the sign of y picks the direction.
    always_comb begin
      xs  = $signed(cur.x) >>> i;
      ys  = $signed(cur.y) >>> i;
      nxt = cur;
      if (!cur.y[CW-1]) begin
        nxt.x = cur.x + ys;
        nxt.y = cur.y - xs;
        nxt.z = cur.z + cfw_atan(i);
      end else begin
        nxt.x = cur.x - ys;
        nxt.y = cur.y + xs;
        nxt.z = cur.z - cfw_atan(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv[i]) begin
        vld_q[i] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[i] && cur_vld) begin
        stg_q[i] <= nxt;
      end
    end
  end

endmodule

/* rtl/carrot_follow_wheel_pwm.sv */
// Follow-the-carrot steering: pose and lookahead point in, wheel PWM commands out.
// Accepted word to result: input register, CORDIC stages, then the post stages.
// Throughput: one word per cycle unless stalled; CORDIC and multiplier stages pipelined.
// A stalled output backs up stage by stage, so empty stages still take new words.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the register defaults.
module carrot_follow_wheel_pwm import cfw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  cfw_pose_if.sink  pose_i,
  cfw_pwm_if.source pwm_o,
  cfw_cfg_if.sink   cfg_i
);

  // Configuration registers
  logic [15:0]        gain_q;
  logic [9:0]         half_q;
  logic signed [11:0] fwd_q;
  logic [15:0]        slope_q;
  logic signed [23:0] offset_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= RST_GAIN;
      half_q   <= RST_HALF;
      fwd_q    <= RST_FWD;
      slope_q  <= RST_SLOPE;
      offset_q <= RST_OFFSET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ANGULAR_GAIN:  gain_q   <= cfg_i.data[15:0];
        CFG_HALF_AXLE:     half_q   <= cfg_i.data[9:0];
        CFG_FORWARD_SPEED: fwd_q    <= cfg_i.data[11:0];
        CFG_PWM_SLOPE:     slope_q  <= cfg_i.data[15:0];
        CFG_PWM_OFFSET:    offset_q <= cfg_i.data[23:0];
        default: ;
      endcase
    end
  end

  // Input stage: difference vector, turned into the right half plane.
  cfw_cordic_t        pre_d;
  cfw_cordic_t        pre_q;
  logic               pre_vld_q;
  logic               pre_adv;
  logic               cor_in_ready;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;

  always_comb begin
    dx = $signed({pose_i.target_x[15], pose_i.target_x})
       - $signed({pose_i.pose_x[15], pose_i.pose_x});
    dy = $signed({pose_i.target_y[15], pose_i.target_y})
       - $signed({pose_i.pose_y[15], pose_i.pose_y});
    x0 = $signed({{(CW-25){dx[16]}}, dx, 8'h00});
    y0 = $signed({{(CW-25){dy[16]}}, dy, 8'h00});
    pre_d.is_zero = (dx == '0) && (dy == '0);
    pre_d.heading = pose_i.pose_heading;
    if (dx[16]) begin
      pre_d.x = -x0;
      pre_d.y = -y0;
      pre_d.z = Z_HALF;
    end else begin
      pre_d.x = x0;
      pre_d.y = y0;
      pre_d.z = '0;
    end
  end

  assign pre_adv      = ~pre_vld_q | cor_in_ready;
  assign pose_i.ready = pre_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else if (pre_adv) begin
      pre_vld_q <= pose_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pre_adv && pose_i.valid) begin
      pre_q <= pre_d;
    end
  end

  // Bearing from the CORDIC
  cfw_cordic_t cor_out;
  logic        cor_out_valid;
  logic [NPOST:0]   adv;
  logic [NPOST-1:0] post_vld_q;
  logic [NPOST-1:0] post_vin;
  logic [NPOST-1:0] ld;

  cfw_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pre_vld_q),
    .in_ready_o  (cor_in_ready),
    .in_data_i   (pre_q),
    .out_valid_o (cor_out_valid),
    .out_ready_i (adv[0]),
    .out_data_o  (cor_out)
  );

  // Valid bits of the stages after the CORDIC.
  assign post_vin   = {post_vld_q[NPOST-2:0], cor_out_valid};
  assign adv[NPOST] = pwm_o.ready;

  for (genvar k = 0; k < NPOST; k++) begin : g_adv
    assign adv[k] = ~post_vld_q[k] | adv[k+1];
    assign ld[k]  = adv[k] & post_vin[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_vld_q <= '0;
    end else begin
      for (int k = 0; k < NPOST; k++) begin
        if (adv[k]) begin
          post_vld_q[k] <= post_vin[k];
        end
      end
    end
  end

  // Stage 0: round the angle to 16 bits and subtract the heading.
  logic [ZW-1:0]          z_fin;
  logic [ZW-1:0]          z_rnd;
  logic signed [ERR_W-1:0] err_d;
  logic signed [ERR_W-1:0] err_q [NPOST];

  always_comb begin
    z_fin = cor_out.is_zero ? '0 : cor_out.z;
    z_rnd = z_fin + Z_ROUND;
    err_d = $signed(z_rnd[ZW-1:ZW-ERR_W] - cor_out.heading);
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      err_q[0] <= err_d;
    end
  end

  // The heading error rides along to the output.
  for (genvar k = 1; k < NPOST; k++) begin : g_err
    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        err_q[k] <= err_q[k-1];
      end
    end
  end

  // Stage 1: gain times error.
  logic signed [32:0] p1_q;
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      p1_q <= $signed({1'b0, gain_q}) * err_q[0];
    end
  end

  // Stage 2: times half the axle width.
  logic signed [43:0] p2_q;
  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      p2_q <= p1_q * $signed({1'b0, half_q});
    end
  end

  // Stage 3: times 2*pi in Q16, split into two partial products.
  logic [40:0]        lo_q;
  logic signed [41:0] hi_q;
  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      lo_q <= p2_q[21:0] * TWO_PI_Q16;
      hi_q <= $signed(p2_q[43:22]) * $signed({1'b0, TWO_PI_Q16});
    end
  end

  // Stage 4: join the partial products and round to Q8 mm/s.
  logic [63:0]          sum36;
  logic signed [DW-1:0] diff_q;
  always_comb begin
    sum36 = {hi_q, 22'b0} + {23'b0, lo_q} + RND_HALF36;
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      diff_q <= $signed(sum36[36+DW-1:36]);
    end
  end

  // Stage 5: wheel speeds around the forward speed.
  logic signed [VW-1:0] fwd_ext;
  logic signed [VW-1:0] diff_ext;
  logic signed [VW-1:0] vl_q;
  logic signed [VW-1:0] vr_q;
  always_comb begin
    fwd_ext  = $signed({{(VW-20){fwd_q[11]}}, fwd_q, 8'h00});
    diff_ext = $signed({{(VW-DW){diff_q[DW-1]}}, diff_q});
  end

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      vl_q <= fwd_ext - diff_ext;
      vr_q <= fwd_ext + diff_ext;
    end
  end

  // Stage 6: slope and offset in Q16.
  logic signed [AW-1:0] accl_q;
  logic signed [AW-1:0] accr_q;
  logic signed [31:0]   off_ext;
  assign off_ext = $signed({offset_q, 8'h00});

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      accl_q <= $signed({1'b0, slope_q}) * vl_q + off_ext;
      accr_q <= $signed({1'b0, slope_q}) * vr_q + off_ext;
    end
  end

  // Truncate toward zero and clip to 16 bits; the top bit flags clipping.
  function automatic logic [16:0] pwm_clip(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] t;
    logic [AW-17:0]       p;
    t = acc + (acc[AW-1] ? AW'(16'hFFFF) : AW'(0));
    p = t[AW-1:16];
    if (!p[AW-17] && (p[AW-17:15] != '0)) begin
      return {1'b1, 16'h7FFF};
    end else if (p[AW-17] && (~p[AW-17:15] != '0)) begin
      return {1'b1, 16'h8000};
    end
    return {1'b0, p[15:0]};
  endfunction

  // Stage 7: output register.
  logic [16:0] cl_l;
  logic [16:0] cl_r;
  logic signed [15:0] pwm_l_q;
  logic signed [15:0] pwm_r_q;
  logic               sat_q;

  always_comb begin
    cl_l = pwm_clip(accl_q);
    cl_r = pwm_clip(accr_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      pwm_l_q <= cl_l[15:0];
      pwm_r_q <= cl_r[15:0];
      sat_q   <= cl_l[16] | cl_r[16];
    end
  end

  assign pwm_o.valid         = post_vld_q[NPOST-1];
  assign pwm_o.pwm_left      = pwm_l_q;
  assign pwm_o.pwm_right     = pwm_r_q;
  assign pwm_o.heading_error = err_q[NPOST-1];
  assign pwm_o.saturated     = sat_q;

endmodule

/* rtl/cfw_checker.sv */
// Port-level checks on the steering block, attached to the top level by bind.
// Depends on assert_macros.svh for the assertion forms.
`include "assert_macros.svh"

module cfw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] pwm_left_i,
  input logic [15:0] pwm_right_i,
  input logic [15:0] heading_error_i,
  input logic        saturated_i
);

  // A result word waits until it is taken.
  `CFW_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

  // A waiting result word does not change.
  `CFW_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(pwm_left_i) && $stable(pwm_right_i) && $stable(heading_error_i) && $stable(saturated_i), "result changed while stalled")

  // The clip flag means one wheel sits on a rail.
  `CFW_ASSERT_IMPL(a_sat_rail, out_valid_i && saturated_i, pwm_left_i == 16'h7FFF || pwm_left_i == 16'h8000 || pwm_right_i == 16'h7FFF || pwm_right_i == 16'h8000, "clip flag without a clipped wheel")

  // The input only stalls when the pipeline is full behind a stalled output.
  `CFW_ASSERT_IMPL(a_stall_full, !in_ready_i, out_valid_i && !out_ready_i, "input stalled with room in the pipeline")

endmodule

bind carrot_follow_wheel_pwm cfw_checker u_cfw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (pose_i.ready),
  .out_valid_i     (pwm_o.valid),
  .out_ready_i     (pwm_o.ready),
  .pwm_left_i      (pwm_o.pwm_left),
  .pwm_right_i     (pwm_o.pwm_right),
  .heading_error_i (pwm_o.heading_error),
  .saturated_i     (pwm_o.saturated)
);

/* bench/carrot_follow_wheel_pwm_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for carrot_follow_wheel_pwm: a table of steering cases, then random poses
// over several register settings; words checked against typed or bit-exact predicted commands.
// Depends on cfw_pkg, the interfaces in cfw_if.sv and the block itself.
module carrot_follow_wheel_pwm_test;
  import cfw_pkg::*;

  localparam int     NUM_REGS        = 5;
  localparam int     NUM_PHASES      = 10;
  localparam int     ITEMS_PER_PHASE = 175;
  localparam int     PIPE_LATENCY    = 1 + CORDIC_STAGES + NPOST;
  // The slowest correct run is about 1800 words under the longest gaps and stalls;
  // the limit leaves plenty of headroom over that.
  localparam longint CYCLE_LIMIT     = 1000000;
  localparam int     MAX_REPORTS     = 60;

  // Steering arithmetic constants.
  localparam int             ARC_LEN          = 24;
  localparam logic [23:0]    HALF_TURN        = 24'h800000;
  localparam longint         RAD_PER_TURN_Q16 = 411775;
  localparam longint         HALF_LSB36       = 64'sd34359738368;
  localparam longint         PWM_MAX          = 32767;
  localparam longint         PWM_MIN          = -32768;

  // atan(2^-i) in units of 2^-24 turn.
  localparam logic [23:0] ARC_Q24 [ARC_LEN] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
    24'd41718, 24'd20860, 24'd10430, 24'd5215, 24'd2608, 24'd1304,
    24'd652, 24'd326, 24'd163, 24'd81, 24'd41, 24'd20,
    24'd10, 24'd5, 24'd3, 24'd1, 24'd1, 24'd0
  };

  typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_e;

  typedef struct packed {
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] heading;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } pose_word_t;

  typedef struct packed {
    logic signed [15:0] pwm_left;
    logic signed [15:0] pwm_right;
    logic signed [15:0] heading_error;
    logic               saturated;
  } wheel_cmd_t;

  typedef struct packed {
    pose_word_t pose;
    logic       typed;
    wheel_cmd_t cmd;
  } steer_row_t;

  localparam wheel_cmd_t NO_CMD = '0;
  // Reset setting, target on the pose and heading zero: no turn, both wheels at cruise.
  localparam wheel_cmd_t PARKED_CMD = '{16'sd2319, 16'sd2319, 16'sd0, 1'b0};

  localparam int NUM_ROWS = 21;
  localparam steer_row_t STEER_ROWS [NUM_ROWS] = '{
    // Target on the pose, at the center and at the corners of the field.
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, PARKED_CMD},
    '{'{16'sh7FFF, 16'sh8000, 16'sd0, 16'sh7FFF, 16'sh8000}, 1'b1, PARKED_CMD},
    '{'{16'sh8000, 16'sh7FFF, 16'sd0, 16'sh8000, 16'sh7FFF}, 1'b1, PARKED_CMD},
    '{'{16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0}, 1'b0, NO_CMD},
    '{'{16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0}, 1'b0, NO_CMD},
    // Straight ahead and straight behind.
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd1000, 16'sd0}, 1'b0, NO_CMD},
    '{'{16'sd0, 16'sd0, 16'sd0, -16'sd1000, 16'sd0}, 1'b0, NO_CMD},
    '{'{16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0}, 1'b0, NO_CMD},
    // Target on the y axis, both sides.
    '{'{16'sd0, 16'sd0, 16'sh4000, 16'sd0, 16'sd1000}, 1'b0, NO_CMD},
    '{'{16'sd0, 16'sd0, 16'shC000, 16'sd0, -16'sd1000}, 1'b0, NO_CMD},
    // Widest offsets in x and y.
    '{'{16'sh8000, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0}, 1'b0, NO_CMD},
    '{'{16'sh7FFF, 16'sd0, 16'sd0, 16'sh8000, 16'sd0}, 1'b0, NO_CMD},
    '{'{16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sh7FFF}, 1'b0, NO_CMD},
    '{'{16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sh8000}, 1'b0, NO_CMD},
    '{'{16'sh8000, 16'sh8000, 16'sh2000, 16'sh7FFF, 16'sh7FFF}, 1'b0, NO_CMD},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000}, 1'b0, NO_CMD},
    '{'{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF}, 1'b0, NO_CMD},
    // Small offsets in the rear and front quadrants.
    '{'{16'sd0, 16'sd0, 16'sh8000, -16'sd3, 16'sd5}, 1'b0, NO_CMD},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1}, 1'b0, NO_CMD},
    '{'{16'sd0, 16'sd0, -16'sd1, 16'sd1, -16'sd1}, 1'b0, NO_CMD},
    '{'{16'sd1234, -16'sd567, 16'sh1234, -16'sd890, 16'sd4321}, 1'b0, NO_CMD}
  };

  logic clk_i;
  logic rst_ni;

  cfw_pose_if pose_bus ();
  cfw_pwm_if  pwm_bus ();
  cfw_cfg_if  cfg_bus ();

  carrot_follow_wheel_pwm uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pose_i (pose_bus),
    .pwm_o  (pwm_bus),
    .cfg_i  (cfg_bus)
  );

  // Register copies used by the predictor, starting from the reset values.
  logic [15:0]        gain_q12  = RST_GAIN;
  logic [9:0]         half_axle = RST_HALF;
  logic signed [11:0] fwd_speed = RST_FWD;
  logic [15:0]        slope_q8  = RST_SLOPE;
  logic signed [23:0] offset_q8 = RST_OFFSET;

  wheel_cmd_t wheel_cmd_q [$];
  pace_e      src_pace  = PACE_FULL;
  pace_e      sink_pace = PACE_FULL;
  int         errors    = 0;
  longint     cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    while (cycle_count <= CYCLE_LIMIT) @(posedge clk_i) cycle_count++;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("cycle %0d: %s", cycle_count, msg);
  endtask

  // No gap at full pace; otherwise no gap or a short one, and now and then a long one.
  function automatic int pick_gap(input pace_e pace);
    int r;
    r = $urandom_range(0, 99);
    if (pace == PACE_FULL) return 0;
    if (r < ((pace == PACE_LIGHT) ? 75 : 35)) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(12, 48);
  endfunction

  // PWM counts for one wheel speed in Q8, truncated toward zero and clipped.
  function automatic logic signed [15:0] wheel_pwm(input longint speed_q8, output logic clipped);
    longint acc, counts;
    acc = longint'(slope_q8) * speed_q8 + longint'(offset_q8) * 256;
    counts = (acc < 0) ? -((-acc) >>> 16) : (acc >>> 16);
    clipped = 1'b0;
    if (counts > PWM_MAX) begin
      clipped = 1'b1;
      counts = PWM_MAX;
    end else if (counts < PWM_MIN) begin
      clipped = 1'b1;
      counts = PWM_MIN;
    end
    return 16'(counts);
  endfunction

  // Bearing by CORDIC, heading error, then the two wheel commands.
  function automatic wheel_cmd_t follow_carrot(input pose_word_t p);
    longint dx, dy, vx, vy, sx, sy, turn, diff, cruise;
    logic [23:0] ang;
    logic [24:0] ang_rnd;
    logic [15:0] bearing;
    logic clip_l, clip_r;
    int i;
    wheel_cmd_t c;
    dx = longint'(p.target_x) - longint'(p.pose_x);
    dy = longint'(p.target_y) - longint'(p.pose_y);
    ang = '0;
    // A target on the pose keeps bearing zero.
    if (dx != 0 || dy != 0) begin
      vx = dx * 256;
      vy = dy * 256;
      if (dx < 0) begin
        vx = -vx;
        vy = -vy;
        ang = HALF_TURN;
      end
      for (i = 0; i < CORDIC_STAGES && i < ARC_LEN; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (vy >= 0) begin
          vx += sy;
          vy -= sx;
          ang += ARC_Q24[i];
        end else begin
          vx -= sy;
          vy += sx;
          ang -= ARC_Q24[i];
        end
      end
    end
    ang_rnd = {1'b0, ang} + 25'd128;
    bearing = ang_rnd[23:8];
    c.heading_error = bearing - p.heading;
    turn = longint'(gain_q12) * longint'(c.heading_error) * longint'(half_axle);
    diff = (turn * RAD_PER_TURN_Q16 + HALF_LSB36) >>> 36;
    cruise = longint'(fwd_speed) * 256;
    c.pwm_left = wheel_pwm(cruise - diff, clip_l);
    c.pwm_right = wheel_pwm(cruise + diff, clip_r);
    c.saturated = clip_l | clip_r;
    return c;
  endfunction

  // Offer one pose word after a random gap and record its command once accepted.
  task automatic send_pose(input pose_word_t p, input logic typed, input wheel_cmd_t typed_cmd);
    int gap;
    gap = pick_gap(src_pace);
    if (gap > 0) begin
      pose_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pose_bus.valid        <= 1'b1;
    pose_bus.pose_x       <= p.pose_x;
    pose_bus.pose_y       <= p.pose_y;
    pose_bus.pose_heading <= p.heading;
    pose_bus.target_x     <= p.target_x;
    pose_bus.target_y     <= p.target_y;
    do @(posedge clk_i); while (!pose_bus.ready);
    wheel_cmd_q.push_back(typed ? typed_cmd : follow_carrot(p));
  endtask

  // Hold off the pose side until every pending command has come back.
  task automatic drain();
    pose_bus.valid <= 1'b0;
    do @(posedge clk_i); while (wheel_cmd_q.size() != 0);
  endtask

  // One register write; valid stays high so writes can follow back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CFG_ANGULAR_GAIN:  gain_q12  = val[15:0];
      CFG_HALF_AXLE:     half_axle = val[9:0];
      CFG_FORWARD_SPEED: fwd_speed = val[11:0];
      CFG_PWM_SLOPE:     slope_q8  = val[15:0];
      CFG_PWM_OFFSET:    offset_q8 = val;
      default: ;
    endcase
  endtask

  // Result side: random stalls, and each accepted word checked against the oldest command.
  initial begin
    int stall;
    wheel_cmd_t want;
    stall = 0;
    pwm_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pwm_bus.valid && pwm_bus.ready) begin
        if (wheel_cmd_q.size() == 0) begin
          flag_error("result word with no command pending");
        end else begin
          want = wheel_cmd_q.pop_front();
          if (pwm_bus.pwm_left !== want.pwm_left)
            flag_error($sformatf("pwm_left %0d, want %0d", pwm_bus.pwm_left, want.pwm_left));
          if (pwm_bus.pwm_right !== want.pwm_right)
            flag_error($sformatf("pwm_right %0d, want %0d", pwm_bus.pwm_right,
                                 want.pwm_right));
          if (pwm_bus.heading_error !== want.heading_error)
            flag_error($sformatf("heading_error %0d, want %0d", pwm_bus.heading_error,
                                 want.heading_error));
          if (pwm_bus.saturated !== want.saturated)
            flag_error($sformatf("saturated %b, want %b", pwm_bus.saturated,
                                 want.saturated));
        end
      end
      if (stall > 0) begin
        stall--;
        pwm_bus.ready <= 1'b0;
      end else begin
        pwm_bus.ready <= 1'b1;
        if ($urandom_range(0, 99) < ((sink_pace == PACE_HEAVY) ? 25 : 8))
          stall = pick_gap(sink_pace);
      end
    end
  end

  // Stimulus: reset, the directed table, then one random phase per register setting.
  initial begin
    pose_word_t p;
    logic [CFG_DATA_W-1:0] val [NUM_REGS];
    int ph, n, first, j;
    rst_ni                <= 1'b0;
    pose_bus.valid        <= 1'b0;
    pose_bus.pose_x       <= '0;
    pose_bus.pose_y       <= '0;
    pose_bus.pose_heading <= '0;
    pose_bus.target_x     <= '0;
    pose_bus.target_y     <= '0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= '0;
    cfg_bus.data          <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      src_pace  = pace_e'(ph % 3);
      sink_pace = pace_e'((ph + ph / 3) % 3);
      if (ph == 0) begin
        foreach (STEER_ROWS[k])
          send_pose(STEER_ROWS[k].pose, STEER_ROWS[k].typed, STEER_ROWS[k].cmd);
      end else begin
        drain();
        // Register order: gain, half axle, forward speed, slope, offset.
        // Upper data bits beyond a register's width are junk on purpose.
        case (ph)
          1: val = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFF7FF, 24'hFFFFFF, 24'h7FFFFF};
          2: val = '{24'hFF0000, 24'hFFFC00, 24'hFFF800, 24'hFF0000, 24'h800000};
          3: val = '{24'h001000, 24'h0003FF, 24'hFFFFFF, 24'h000001, 24'hFFFFFF};
          NUM_PHASES - 1: val = '{24'(RST_GAIN), 24'(RST_HALF), 24'(RST_FWD),
                                  24'(RST_SLOPE), 24'(RST_OFFSET)};
          default: begin
            val[0] = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 8192));
            val[1] = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 200));
            val[2] = $urandom_range(0, 1) ? 24'($urandom)
                                          : 24'(int'($urandom_range(0, 600)) - 300);
            val[3] = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 20000));
            val[4] = $urandom_range(0, 1) ? 24'($urandom)
                                          : 24'(int'($urandom_range(0, 600000)) - 300000);
          end
        endcase
        // An index past the register list must leave every register alone.
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1)), 24'($urandom));
        first = $urandom_range(0, NUM_REGS - 1);
        for (j = 0; j < NUM_REGS; j++)
          write_reg(CFG_IDX_W'((first + j) % NUM_REGS), val[(first + j) % NUM_REGS]);
        cfg_bus.valid <= 1'b0;
      end

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == ITEMS_PER_PHASE / 2) drain();
        p.pose_x   = 16'($urandom);
        p.pose_y   = 16'($urandom);
        p.heading  = 16'($urandom);
        p.target_x = 16'($urandom);
        p.target_y = 16'($urandom);
        case ($urandom_range(0, 9))
          // Nearby lookahead point, the usual case when following a path.
          5, 6: begin
            p.target_x = p.pose_x + 16'(int'($urandom_range(0, 512)) - 256);
            p.target_y = p.pose_y + 16'(int'($urandom_range(0, 512)) - 256);
          end
          // Target level with the pose on one axis.
          7: begin
            if ($urandom_range(0, 1)) p.target_y = p.pose_y;
            else p.target_x = p.pose_x;
          end
          8: begin
            p.target_x = p.pose_x;
            p.target_y = p.pose_y;
          end
          // Coordinates at the ends of their range.
          9: begin
            p.pose_x   = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            p.pose_y   = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            p.target_x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            p.target_y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          end
          default: ;
        endcase
        send_pose(p, 1'b0, NO_CMD);
      end
    end

    drain();
    repeat (PIPE_LATENCY + 8) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
